// ===== src/kwm_pkg.sv =====
// Shared types, constants and functions of the k-mer window minimizer.
package kwm_pkg;

  localparam int BASE_W     = 8;
  localparam int VAL_W      = 62;
  localparam int K_W        = 5;
  localparam int W_W        = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int OUT_POS_W  = 32;
  localparam int OUT_DATA_W = 96;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_POS_W - VAL_W;
  localparam int MIX_CNT_W  = 2;

  localparam logic [K_W-1:0] KMER_LENGTH_RST   = 5'd15;
  localparam logic [W_W-1:0] WINDOW_LENGTH_RST = 6'd5;

  // Nucleotide codes; any byte outside the alphabet yields all ones.
  localparam logic [BASE_W-1:0] NT_CODE0 = 8'd0;
  localparam logic [BASE_W-1:0] NT_CODE1 = 8'd1;
  localparam logic [BASE_W-1:0] NT_CODE2 = 8'd2;
  localparam logic [BASE_W-1:0] NT_CODE3 = 8'd3;
  localparam logic [BASE_W-1:0] NT_BAD   = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KMER_LENGTH   = 1'b0,
    REG_WINDOW_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIX,
    S_UPDATE
  } state_t;

  typedef enum logic [MIX_CNT_W-1:0] {
    MIX_R0,
    MIX_R1,
    MIX_R2,
    MIX_R3
  } mix_round_t;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_ONE,
    SH_TWO
  } shift_t;

  typedef struct packed {
    logic   upd;
    shift_t shift;
  } kwm_ctrl_t;

  function automatic logic [BASE_W-1:0] decode_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] u;
    u = b;
    if (b >= "a" && b <= "z") begin
      u = b - 8'h20;
    end
    case (u)
      "-", "A", "D", "N", "R", "W": decode_base = NT_CODE0;
      "B", "C", "M", "S":           decode_base = NT_CODE1;
      "G", "K", "V":                decode_base = NT_CODE2;
      "H", "T", "U", "Y":           decode_base = NT_CODE3;
      default:                      decode_base = NT_BAD;
    endcase
  endfunction

  // One round of the masked integer mix; four rounds give the full hash.
  function automatic logic [VAL_W-1:0] mix_step(input logic [VAL_W-1:0] v,
                                                input logic [VAL_W-1:0] m,
                                                input mix_round_t sel);
    logic [VAL_W-1:0] a;
    a = '0;
    case (sel)
      MIX_R0: begin
        a = (~v + (v << 21)) & m;
        mix_step = a ^ (a >> 24);
      end
      MIX_R1: begin
        a = (v + (v << 3) + (v << 8)) & m;
        mix_step = a ^ (a >> 14);
      end
      MIX_R2: begin
        a = (v + (v << 2) + (v << 4)) & m;
        mix_step = a ^ (a >> 28);
      end
      default: begin
        mix_step = (v + (v << 31)) & m;
      end
    endcase
  endfunction

endpackage

// ===== src/kwm_mix.sv =====
// Iterative hash unit: applies one mix round per cycle to a loaded k-mer.
module kwm_mix import kwm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] value_in,
  input  logic [VAL_W-1:0] mask,
  output logic [VAL_W-1:0] hash,
  output logic             done
);

  logic [VAL_W-1:0]     v_r, v_nxt;
  logic [MIX_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;

  always_comb begin
    v_nxt    = v_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      v_nxt    = value_in;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt   = mix_step(v_r, mask, mix_round_t'(cnt_r));
      cnt_nxt = cnt_r + MIX_CNT_W'(1);
      if (mix_round_t'(cnt_r) == MIX_R3) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  // The hash is final in the cycle after the last round.
  assign done = busy_r && (mix_round_t'(cnt_r) == MIX_R3);
  assign hash = v_r;

endmodule

// ===== src/kwm_cell.sv =====
// One window slot: holds a candidate and shifts toward the front of the chain.
module kwm_cell import kwm_pkg::*; #(
  parameter int IDX   = 0,
  parameter int OCC_W = 6,
  parameter int POS_W = 32
) (
  input  logic             clk,
  input  kwm_ctrl_t        ctrl,
  input  logic [OCC_W-1:0] occ,
  input  logic [VAL_W-1:0] new_hash,
  input  logic [POS_W-1:0] new_pos,
  input  logic [VAL_W-1:0] new_val,
  input  logic             prev_kept,
  input  logic [VAL_W-1:0] nb1_hash,
  input  logic [POS_W-1:0] nb1_pos,
  input  logic [VAL_W-1:0] nb1_val,
  input  logic             nb1_kept,
  input  logic             nb1_ins,
  input  logic [VAL_W-1:0] nb2_hash,
  input  logic [POS_W-1:0] nb2_pos,
  input  logic [VAL_W-1:0] nb2_val,
  input  logic             nb2_kept,
  input  logic             nb2_ins,
  output logic [VAL_W-1:0] hash,
  output logic [POS_W-1:0] pos,
  output logic [VAL_W-1:0] val,
  output logic             kept,
  output logic             ins
);

  logic [VAL_W-1:0] hash_r, hash_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             src_kept, src_ins;
  logic [VAL_W-1:0] src_hash, src_val;
  logic [POS_W-1:0] src_pos;

  // A live slot survives the new entry unless its hash is larger.
  assign kept = (OCC_W'(IDX) < occ) && (hash_r <= new_hash);
  assign ins  = prev_kept && !kept;

  always_comb begin
    src_kept = 1'b0;
    src_ins  = 1'b0;
    src_hash = hash_r;
    src_pos  = pos_r;
    src_val  = val_r;
    case (ctrl.shift)
      SH_NONE: begin
        src_kept = kept;
        src_ins  = ins;
      end
      SH_ONE: begin
        src_kept = nb1_kept;
        src_ins  = nb1_ins;
        src_hash = nb1_hash;
        src_pos  = nb1_pos;
        src_val  = nb1_val;
      end
      SH_TWO: begin
        src_kept = nb2_kept;
        src_ins  = nb2_ins;
        src_hash = nb2_hash;
        src_pos  = nb2_pos;
        src_val  = nb2_val;
      end
      default: begin
        src_kept = 1'b0;
        src_ins  = 1'b0;
      end
    endcase
  end

  always_comb begin
    hash_nxt = hash_r;
    pos_nxt  = pos_r;
    val_nxt  = val_r;
    if (ctrl.upd) begin
      if (src_kept) begin
        hash_nxt = src_hash;
        pos_nxt  = src_pos;
        val_nxt  = src_val;
      end else if (src_ins) begin
        hash_nxt = new_hash;
        pos_nxt  = new_pos;
        val_nxt  = new_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
  end

  assign hash = hash_r;
  assign pos  = pos_r;
  assign val  = val_r;

endmodule

// ===== src/kmer_window_minimizer_unit.sv =====
// Top level: decodes bases, hashes k-mers and keeps the minimizer window in a cell chain.
// An accepted base goes through the hash rounds (S_MIX) and the window update (S_UPDATE);
// out_tvalid is registered from that update when it emits a minimizer. New bases are taken
// only in S_IDLE; in_tready is low during the four rounds of the hash and the update.
// A waiting result holds an emitting update; in_tready stays low until the word leaves.
// Reset (rst_n, synchronous, active low): k = 15, w = 5, window empty; no clearing pass.
module kmer_window_minimizer_unit import kwm_pkg::*; #(
  parameter int MAX_WINDOW    = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BASE_W-1:0]     in_tdata,   // [7:0] base
  input  logic                  in_tlast,   // end_of_sequence
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] kmer_position, [93:32] kmer_value
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int OCC_W = $clog2(MAX_WINDOW + 1);
  localparam int POS_W = POSITION_BITS;
  localparam int NPAD  = MAX_WINDOW + 2;

  state_t state_r, state_nxt;

  logic [K_W-1:0]   kmer_length_r, kmer_length_nxt;
  logic [W_W-1:0]   window_length_r, window_length_nxt;
  logic [VAL_W-1:0] rolling_r, rolling_nxt;
  logic             eos_r, eos_nxt;
  logic [POS_W-1:0] base_index_r, base_index_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [POS_W-1:0] last_pos_r, last_pos_nxt;
  logic             emitted_r, emitted_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [VAL_W-1:0] out_val_r, out_val_nxt;

  logic             accept;
  logic             upd_fire;
  logic             mix_done;
  logic [VAL_W-1:0] mix_hash;
  logic [K_W-1:0]   k_eff;
  logic [W_W-1:0]   w_eff;
  logic [VAL_W-1:0] mask;
  logic [BASE_W-1:0] code;
  logic [VAL_W-1:0] rolling_shift;
  logic [6:0]       kw_thr;
  logic [POS_W-1:0] k_off;
  logic             emit_c;
  logic             ins_cond;
  logic [POS_W-1:0] p_new;
  logic [OCC_W-1:0] np;
  logic             drop1, drop2;
  logic [OCC_W:0]   occ_ins;
  logic [POS_W-1:0] front_pos, front_age;
  logic [63:0]      pos_wide;
  kwm_ctrl_t        ctrl;

  logic [VAL_W-1:0] c_hash [NPAD];
  logic [POS_W-1:0] c_pos  [NPAD];
  logic [VAL_W-1:0] c_val  [NPAD];
  logic             c_kept [NPAD];
  logic             c_ins  [NPAD];

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_comb begin
    kmer_length_nxt   = kmer_length_r;
    window_length_nxt = window_length_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_KMER_LENGTH:   kmer_length_nxt   = cfg_data[K_W-1:0];
        REG_WINDOW_LENGTH: window_length_nxt = cfg_data[W_W-1:0];
        default: begin
          kmer_length_nxt   = kmer_length_r;
          window_length_nxt = window_length_r;
        end
      endcase
    end
  end

  assign k_eff = (kmer_length_r == '0) ? K_W'(1) : kmer_length_r;

  always_comb begin
    if (window_length_r == '0) begin
      w_eff = W_W'(1);
    end else if (9'(window_length_r) > 9'(MAX_WINDOW)) begin
      w_eff = W_W'(MAX_WINDOW);
    end else begin
      w_eff = window_length_r;
    end
  end

  assign mask = ~({VAL_W{1'b1}} << {k_eff, 1'b0});

  // ---------------------------------------------------------------- front end
  assign accept        = in_tvalid && in_tready;
  assign code          = decode_base(in_tdata);
  assign rolling_shift = {rolling_r[VAL_W-3:0], 2'b00};

  kwm_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .value_in ((rolling_shift | VAL_W'(code)) & mask),
    .mask     (mask),
    .hash     (mix_hash),
    .done     (mix_done)
  );

  // ---------------------------------------------------------------- cell chain
  generate
    for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic prev_kept;
      if (i == 0) begin : g_first
        assign prev_kept = 1'b1;
      end else begin : g_rest
        assign prev_kept = c_kept[i-1];
      end
      kwm_cell #(
        .IDX   (i),
        .OCC_W (OCC_W),
        .POS_W (POS_W)
      ) u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occ       (occ_r),
        .new_hash  (mix_hash),
        .new_pos   (p_new),
        .new_val   (rolling_r),
        .prev_kept (prev_kept),
        .nb1_hash  (c_hash[i+1]),
        .nb1_pos   (c_pos[i+1]),
        .nb1_val   (c_val[i+1]),
        .nb1_kept  (c_kept[i+1]),
        .nb1_ins   (c_ins[i+1]),
        .nb2_hash  (c_hash[i+2]),
        .nb2_pos   (c_pos[i+2]),
        .nb2_val   (c_val[i+2]),
        .nb2_kept  (c_kept[i+2]),
        .nb2_ins   (c_ins[i+2]),
        .hash      (c_hash[i]),
        .pos       (c_pos[i]),
        .val       (c_val[i]),
        .kept      (c_kept[i]),
        .ins       (c_ins[i])
      );
    end
  endgenerate

  // Two slots past the end: the first takes the new entry when the last cell is kept.
  assign c_hash[MAX_WINDOW]   = '0;
  assign c_pos[MAX_WINDOW]    = '0;
  assign c_val[MAX_WINDOW]    = '0;
  assign c_kept[MAX_WINDOW]   = 1'b0;
  assign c_ins[MAX_WINDOW]    = c_kept[MAX_WINDOW-1];
  assign c_hash[MAX_WINDOW+1] = '0;
  assign c_pos[MAX_WINDOW+1]  = '0;
  assign c_val[MAX_WINDOW+1]  = '0;
  assign c_kept[MAX_WINDOW+1] = 1'b0;
  assign c_ins[MAX_WINDOW+1]  = 1'b0;

  // The insertion flags are one-hot, so the slot number is an OR of indices.
  always_comb begin
    np = '0;
    for (int j = 0; j <= MAX_WINDOW; j++) begin
      if (c_ins[j]) begin
        np = np | OCC_W'(j);
      end
    end
  end

  // ---------------------------------------------------------------- window control
  assign kw_thr   = 7'(k_eff) + 7'(w_eff) - 7'd1;
  assign k_off    = POS_W'(k_eff - K_W'(1));
  assign emit_c   = (occ_r != '0) && (emitted_r || (base_index_r >= POS_W'(kw_thr))) &&
                    (!emitted_r || (c_pos[0] != last_pos_r));
  assign ins_cond = (occ_r != '0) || (base_index_r >= k_off);
  assign p_new    = base_index_r - k_off;

  assign drop1     = c_kept[MAX_WINDOW-1];
  assign occ_ins   = (OCC_W+1)'(np) + (OCC_W+1)'(1) - (OCC_W+1)'(drop1);
  assign front_pos = drop1 ? c_pos[1] : c_pos[0];
  assign front_age = p_new - front_pos;
  assign drop2     = (occ_ins > (OCC_W+1)'(1)) && (front_age >= POS_W'(w_eff));

  always_comb begin
    ctrl.upd = upd_fire && ins_cond;
    if (drop1 && drop2) begin
      ctrl.shift = SH_TWO;
    end else if (drop1 || drop2) begin
      ctrl.shift = SH_ONE;
    end else begin
      ctrl.shift = SH_NONE;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept)   state_nxt = S_MIX;
      S_MIX:    if (mix_done) state_nxt = S_UPDATE;
      S_UPDATE: if (upd_fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == S_IDLE);
    upd_fire  = (state_r == S_UPDATE) && !(emit_c && out_valid_r && !out_tready);
  end

  // ---------------------------------------------------------------- state update
  always_comb begin
    rolling_nxt    = rolling_r;
    eos_nxt        = eos_r;
    base_index_nxt = base_index_r;
    occ_nxt        = occ_r;
    last_pos_nxt   = last_pos_r;
    emitted_nxt    = emitted_r;
    if (accept) begin
      rolling_nxt = (rolling_shift | VAL_W'(code)) & mask;
      eos_nxt     = in_tlast;
    end
    if (upd_fire) begin
      if (eos_r) begin
        rolling_nxt    = '0;
        base_index_nxt = '0;
        occ_nxt        = '0;
        last_pos_nxt   = '0;
        emitted_nxt    = 1'b0;
      end else begin
        base_index_nxt = base_index_r + POS_W'(1);
        if (ins_cond) begin
          occ_nxt = OCC_W'(occ_ins - (OCC_W+1)'(drop2));
        end
        if (emit_c) begin
          last_pos_nxt = c_pos[0];
          emitted_nxt  = 1'b1;
        end
      end
    end
  end

  assign pos_wide = 64'(c_pos[0]);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_val_nxt   = out_val_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (upd_fire && emit_c) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = pos_wide[OUT_POS_W-1:0];
      out_val_nxt   = c_val[0];
    end
  end

  always_ff @(posedge clk) begin
    out_pos_r <= out_pos_nxt;
    out_val_r <= out_val_nxt;
    eos_r     <= eos_nxt;
    if (!rst_n) begin
      state_r         <= S_IDLE;
      kmer_length_r   <= KMER_LENGTH_RST;
      window_length_r <= WINDOW_LENGTH_RST;
      rolling_r       <= '0;
      base_index_r    <= '0;
      occ_r           <= '0;
      last_pos_r      <= '0;
      emitted_r       <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      kmer_length_r   <= kmer_length_nxt;
      window_length_r <= window_length_nxt;
      rolling_r       <= rolling_nxt;
      base_index_r    <= base_index_nxt;
      occ_r           <= occ_nxt;
      last_pos_r      <= last_pos_nxt;
      emitted_r       <= emitted_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), out_val_r, out_pos_r};

  // ---------------------------------------------------------------- assertions
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(MAX_WINDOW))
    else $error("window occupancy above its depth");

  a_accept_starts_mix: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_MIX))
    else $error("accepted word did not start the hash");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(upd_fire && emit_c))
    else $error("result appeared outside a window update");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_fire && eos_r) |=> ((occ_r == '0) && !emitted_r && (base_index_r == '0)))
    else $error("end of sequence did not clear the window");

endmodule
